[design/i2cm_pkg.sv]
// Shared types and constants for the I2C register-access master.
// Holds phase and byte-kind codes, transaction modes, register indexes and the
// tick item / result structs used by i2cm_core and the top level.
`default_nettype none

package i2cm_pkg;

    // Bus phases
    localparam logic [4:0] P_IDLE     = 5'd0;
    localparam logic [4:0] P_RS_LOW   = 5'd1;
    localparam logic [4:0] P_ST_HIGH  = 5'd2;
    localparam logic [4:0] P_ST_SDA   = 5'd3;
    localparam logic [4:0] P_TX_LOW   = 5'd4;
    localparam logic [4:0] P_TX_HIGH  = 5'd5;
    localparam logic [4:0] P_ACK_LOW  = 5'd6;
    localparam logic [4:0] P_ACK_HIGH = 5'd7;
    localparam logic [4:0] P_ACK_WAIT = 5'd8;
    localparam logic [4:0] P_GAP      = 5'd9;
    localparam logic [4:0] P_RX_LOW   = 5'd10;
    localparam logic [4:0] P_RX_HIGH  = 5'd11;
    localparam logic [4:0] P_MA_LOW   = 5'd12;
    localparam logic [4:0] P_MA_HIGH  = 5'd13;
    localparam logic [4:0] P_SP_LOW   = 5'd14;
    localparam logic [4:0] P_SP_HIGH  = 5'd15;
    localparam logic [4:0] P_SP_END   = 5'd16;

    // Kind of the byte being shifted out
    localparam logic [1:0] K_DEV   = 2'd0;
    localparam logic [1:0] K_REG   = 2'd1;
    localparam logic [1:0] K_DATA  = 2'd2;
    localparam logic [1:0] K_RADDR = 2'd3;

    // Transaction modes
    localparam logic [1:0] MODE_REG_WRITE   = 2'd0;
    localparam logic [1:0] MODE_REG_READ    = 2'd1;
    localparam logic [1:0] MODE_BURST_WRITE = 2'd2;
    localparam logic [1:0] MODE_BURST_READ  = 2'd3;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_PERIOD = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACK_TIMEOUT = 1'd1;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [7:0]  HALF_PERIOD_RST = 8'd1;
    localparam logic [15:0] ACK_TIMEOUT_RST = 16'd5000;

    // Ticks with SCL low between burst write data bytes
    localparam logic [7:0]  BYTE_GAP = 8'd10;

    typedef struct packed {
        logic [7:0]  half_period;
        logic [15:0] ack_timeout;
    } t_cfg;

    typedef struct packed {
        logic       start_request;
        logic [1:0] mode;
        logic [7:0] device_address;
        logic [7:0] register_address;
        logic       has_data;
        logic [7:0] byte_count;
        logic [7:0] write_data;
        logic       sda_in;
    } t_item;

    typedef struct packed {
        logic       scl_release;
        logic       sda_release;
        logic       busy_res;
        logic       byte_taken;
        logic [7:0] read_data;
        logic       read_valid;
        logic       done_res;
        logic       nack_error;
    } t_result;

endpackage

`default_nettype wire

[design/i2cm_core.sv]
// Bus state machine of the I2C register-access master: one step per tick.
// Holds the transaction state; the next state and the tick's pin result come
// from one combinational pass. Uses i2cm_pkg.
`default_nettype none

module i2cm_core (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  i2cm_pkg::t_item    i_item,
    input  i2cm_pkg::t_cfg     i_cfg,
    output i2cm_pkg::t_result  o_res
);

    logic [4:0]  r_phase,      n_phase;
    logic [7:0]  r_delay,      n_delay;
    logic [15:0] r_wait,       n_wait;
    logic [2:0]  r_bit_idx,    n_bit_idx;
    logic [7:0]  r_shift,      n_shift;
    logic [7:0]  r_bytes_left, n_bytes_left;
    logic [1:0]  r_mode,       n_mode;
    logic [7:0]  r_device,     n_device;
    logic [7:0]  r_register,   n_register;
    logic        r_has_data,   n_has_data;
    logic [1:0]  r_kind,       n_kind;
    logic        r_err,        n_err;

    i2cm_pkg::t_result res;

    always_comb begin
        logic       v_exp;
        logic [7:0] v_dec;
        logic       v_burst;
        logic [7:0] v_rx;
        logic [15:0] v_wait_dec;

        n_phase      = r_phase;
        n_delay      = r_delay;
        n_wait       = r_wait;
        n_bit_idx    = r_bit_idx;
        n_shift      = r_shift;
        n_bytes_left = r_bytes_left;
        n_mode       = r_mode;
        n_device     = r_device;
        n_register   = r_register;
        n_has_data   = r_has_data;
        n_kind       = r_kind;
        n_err        = r_err;
        v_burst      = 1'b0;

        res             = '0;
        res.scl_release = 1'b1;
        res.sda_release = 1'b1;

        // Latch a new request only while idle
        if (r_phase == i2cm_pkg::P_IDLE && i_item.start_request) begin
            n_mode     = i_item.mode;
            n_device   = i_item.device_address;
            n_register = i_item.register_address;
            n_has_data = i_item.has_data;
            unique case (i_item.mode)
                i2cm_pkg::MODE_REG_READ:                   n_bytes_left = 8'd1;
                i2cm_pkg::MODE_BURST_WRITE,
                i2cm_pkg::MODE_BURST_READ:                 n_bytes_left = i_item.byte_count;
                default:                                   n_bytes_left = 8'd0;
            endcase
            n_err     = 1'b0;
            n_bit_idx = 3'd0;
            if (i_item.mode == i2cm_pkg::MODE_BURST_READ) begin
                n_shift = i_item.device_address + 8'd1;
                n_kind  = i2cm_pkg::K_RADDR;
            end else begin
                n_shift = i_item.device_address;
                n_kind  = i2cm_pkg::K_DEV;
            end
            n_phase = i2cm_pkg::P_ST_HIGH;
            n_delay = i_cfg.half_period;
        end

        res.busy_res = (n_phase != i2cm_pkg::P_IDLE);
        v_exp        = (n_delay <= 8'd1);
        v_dec        = n_delay - 8'd1;
        v_rx         = {n_shift[6:0], i_item.sda_in};
        v_wait_dec   = n_wait - 16'd1;

        unique case (n_phase)
            i2cm_pkg::P_IDLE: begin
            end
            i2cm_pkg::P_RS_LOW: begin
                res.scl_release = 1'b0;
                if (v_exp) begin
                    n_phase = i2cm_pkg::P_ST_HIGH;
                    n_delay = i_cfg.half_period;
                end else begin
                    n_delay = v_dec;
                end
            end
            i2cm_pkg::P_ST_HIGH: begin
                if (v_exp) begin
                    n_phase = i2cm_pkg::P_ST_SDA;
                    n_delay = i_cfg.half_period;
                end else begin
                    n_delay = v_dec;
                end
            end
            i2cm_pkg::P_ST_SDA: begin
                res.sda_release = 1'b0;
                if (v_exp) begin
                    n_bit_idx = 3'd0;
                    n_phase   = i2cm_pkg::P_TX_LOW;
                    n_delay   = i_cfg.half_period;
                end else begin
                    n_delay = v_dec;
                end
            end
            i2cm_pkg::P_TX_LOW: begin
                res.scl_release = 1'b0;
                res.sda_release = n_shift[7];
                if (v_exp) begin
                    n_phase = i2cm_pkg::P_TX_HIGH;
                    n_delay = i_cfg.half_period;
                end else begin
                    n_delay = v_dec;
                end
            end
            i2cm_pkg::P_TX_HIGH: begin
                res.sda_release = n_shift[7];
                if (v_exp) begin
                    n_delay = i_cfg.half_period;
                    if (n_bit_idx == 3'd7) begin
                        n_phase = i2cm_pkg::P_ACK_LOW;
                    end else begin
                        n_bit_idx = n_bit_idx + 3'd1;
                        n_shift   = {n_shift[6:0], 1'b0};
                        n_phase   = i2cm_pkg::P_TX_LOW;
                    end
                end else begin
                    n_delay = v_dec;
                end
            end
            i2cm_pkg::P_ACK_LOW: begin
                res.scl_release = 1'b0;
                if (v_exp) begin
                    n_phase = i2cm_pkg::P_ACK_HIGH;
                    n_delay = i_cfg.half_period;
                end else begin
                    n_delay = v_dec;
                end
            end
            i2cm_pkg::P_ACK_HIGH: begin
                if (v_exp) begin
                    n_phase = i2cm_pkg::P_ACK_WAIT;
                    n_wait  = i_cfg.ack_timeout;
                end else begin
                    n_delay = v_dec;
                end
            end
            i2cm_pkg::P_ACK_WAIT: begin
                if (!i_item.sda_in) begin
                    // Acknowledged: pick what follows this byte
                    n_delay = i_cfg.half_period;
                    unique case (n_kind)
                        i2cm_pkg::K_DEV: begin
                            n_shift   = n_register;
                            n_bit_idx = 3'd0;
                            n_kind    = i2cm_pkg::K_REG;
                            n_phase   = i2cm_pkg::P_TX_LOW;
                        end
                        i2cm_pkg::K_REG: begin
                            unique case (n_mode)
                                i2cm_pkg::MODE_REG_WRITE: begin
                                    if (n_has_data) begin
                                        n_shift        = i_item.write_data;
                                        n_bit_idx      = 3'd0;
                                        n_kind         = i2cm_pkg::K_DATA;
                                        n_phase        = i2cm_pkg::P_TX_LOW;
                                        res.byte_taken = 1'b1;
                                    end else begin
                                        n_phase = i2cm_pkg::P_SP_LOW;
                                    end
                                end
                                i2cm_pkg::MODE_REG_READ: begin
                                    n_shift = n_device + 8'd1;
                                    n_kind  = i2cm_pkg::K_RADDR;
                                    n_phase = i2cm_pkg::P_RS_LOW;
                                end
                                i2cm_pkg::MODE_BURST_WRITE: v_burst = 1'b1;
                                default:                    n_phase = i2cm_pkg::P_SP_LOW;
                            endcase
                        end
                        i2cm_pkg::K_DATA: begin
                            if (n_mode == i2cm_pkg::MODE_BURST_WRITE) begin
                                if (i2cm_pkg::BYTE_GAP != 8'd0) begin
                                    n_phase = i2cm_pkg::P_GAP;
                                    n_delay = i2cm_pkg::BYTE_GAP;
                                end else begin
                                    v_burst = 1'b1;
                                end
                            end else begin
                                n_phase = i2cm_pkg::P_SP_LOW;
                            end
                        end
                        default: begin
                            if (n_bytes_left != 8'd0) begin
                                n_bit_idx = 3'd0;
                                n_shift   = 8'd0;
                                n_phase   = i2cm_pkg::P_RX_LOW;
                            end else begin
                                n_phase = i2cm_pkg::P_SP_LOW;
                            end
                        end
                    endcase
                end else begin
                    n_wait = v_wait_dec;
                    if (v_wait_dec == 16'd0) begin
                        n_err   = 1'b1;
                        n_phase = i2cm_pkg::P_SP_LOW;
                        n_delay = i_cfg.half_period;
                    end
                end
            end
            i2cm_pkg::P_GAP: begin
                res.scl_release = 1'b0;
                if (v_exp) begin
                    v_burst = 1'b1;
                end else begin
                    n_delay = v_dec;
                end
            end
            i2cm_pkg::P_RX_LOW: begin
                res.scl_release = 1'b0;
                if (v_exp) begin
                    n_phase = i2cm_pkg::P_RX_HIGH;
                    n_delay = i_cfg.half_period;
                end else begin
                    n_delay = v_dec;
                end
            end
            i2cm_pkg::P_RX_HIGH: begin
                if (v_exp) begin
                    n_shift = v_rx;
                    n_delay = i_cfg.half_period;
                    if (n_bit_idx == 3'd7) begin
                        res.read_valid = 1'b1;
                        res.read_data  = v_rx;
                        if (n_bytes_left != 8'd0) begin
                            n_bytes_left = n_bytes_left - 8'd1;
                        end
                        n_phase = i2cm_pkg::P_MA_LOW;
                    end else begin
                        n_bit_idx = n_bit_idx + 3'd1;
                        n_phase   = i2cm_pkg::P_RX_LOW;
                    end
                end else begin
                    n_delay = v_dec;
                end
            end
            i2cm_pkg::P_MA_LOW: begin
                res.scl_release = 1'b0;
                res.sda_release = (n_bytes_left == 8'd0);
                if (v_exp) begin
                    n_phase = i2cm_pkg::P_MA_HIGH;
                    n_delay = i_cfg.half_period;
                end else begin
                    n_delay = v_dec;
                end
            end
            i2cm_pkg::P_MA_HIGH: begin
                res.sda_release = (n_bytes_left == 8'd0);
                if (v_exp) begin
                    n_delay = i_cfg.half_period;
                    if (n_bytes_left != 8'd0) begin
                        n_bit_idx = 3'd0;
                        n_shift   = 8'd0;
                        n_phase   = i2cm_pkg::P_RX_LOW;
                    end else begin
                        n_phase = i2cm_pkg::P_SP_LOW;
                    end
                end else begin
                    n_delay = v_dec;
                end
            end
            i2cm_pkg::P_SP_LOW: begin
                res.scl_release = 1'b0;
                res.sda_release = 1'b0;
                if (v_exp) begin
                    n_phase = i2cm_pkg::P_SP_HIGH;
                    n_delay = i_cfg.half_period;
                end else begin
                    n_delay = v_dec;
                end
            end
            i2cm_pkg::P_SP_HIGH: begin
                res.sda_release = 1'b0;
                if (v_exp) begin
                    n_phase = i2cm_pkg::P_SP_END;
                    n_delay = i_cfg.half_period;
                end else begin
                    n_delay = v_dec;
                end
            end
            i2cm_pkg::P_SP_END: begin
                if (v_exp) begin
                    res.done_res   = 1'b1;
                    res.nack_error = n_err;
                    n_err          = 1'b0;
                    n_phase        = i2cm_pkg::P_IDLE;
                end else begin
                    n_delay = v_dec;
                end
            end
            default: begin
                // Drop back to idle from a code that means nothing
                res.busy_res = 1'b0;
                n_phase      = i2cm_pkg::P_IDLE;
            end
        endcase

        // Next burst write byte, or close the transfer
        if (v_burst) begin
            n_delay = i_cfg.half_period;
            if (n_bytes_left != 8'd0) begin
                n_bytes_left   = n_bytes_left - 8'd1;
                n_shift        = i_item.write_data;
                n_bit_idx      = 3'd0;
                n_kind         = i2cm_pkg::K_DATA;
                n_phase        = i2cm_pkg::P_TX_LOW;
                res.byte_taken = 1'b1;
            end else begin
                n_phase = i2cm_pkg::P_SP_LOW;
            end
        end
    end

    assign o_res = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= i2cm_pkg::P_IDLE;
            r_delay      <= 8'd0;
            r_wait       <= 16'd0;
            r_bit_idx    <= 3'd0;
            r_shift      <= 8'd0;
            r_bytes_left <= 8'd0;
            r_mode       <= 2'd0;
            r_device     <= 8'd0;
            r_register   <= 8'd0;
            r_has_data   <= 1'b0;
            r_kind       <= i2cm_pkg::K_DEV;
            r_err        <= 1'b0;
        end else if (i_en) begin
            r_phase      <= n_phase;
            r_delay      <= n_delay;
            r_wait       <= n_wait;
            r_bit_idx    <= n_bit_idx;
            r_shift      <= n_shift;
            r_bytes_left <= n_bytes_left;
            r_mode       <= n_mode;
            r_device     <= n_device;
            r_register   <= n_register;
            r_has_data   <= n_has_data;
            r_kind       <= n_kind;
            r_err        <= n_err;
        end
    end

    a_done_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en && res.done_res |-> res.busy_res)
        else $error("done reported outside a transaction");

    a_error_with_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en && res.nack_error |-> res.done_res)
        else $error("nack error without done");

    a_read_data_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en && !res.read_valid |-> res.read_data == 8'd0)
        else $error("read data nonzero without read valid");

    a_taken_starts_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en && res.byte_taken |=> r_kind == i2cm_pkg::K_DATA && r_phase == i2cm_pkg::P_TX_LOW)
        else $error("taken byte not shifted out as data");

    a_phase_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> r_phase <= i2cm_pkg::P_SP_END)
        else $error("phase register left the legal range");

endmodule

`default_nettype wire

[design/i2c_master_register_access.sv]
// Top level of the I2C register-access master: request register, bus state
// machine (i2cm_core), result register and the configuration registers.
// Uses i2cm_pkg.
`default_nettype none

// One request is one timing tick of the I2C bus state machine. A request is
// taken every clock cycle while o_stall is low; its result (pin levels and
// status for that tick) is on the result ports out of the result register,
// after the request has passed through the request register.
// The state machine advances once as a request moves from the request
// register into the result register, in a single combinational pass, so the
// sustained rate is one request per cycle; o_stall rises only when the result
// register is full and i_stall holds it. Configuration writes are always
// accepted and apply from the next tick on.
module i2c_master_register_access (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // request channel
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic        i_start_request,
    input  wire logic [1:0]  i_mode,
    input  wire logic [7:0]  i_device_address,
    input  wire logic [7:0]  i_register_address,
    input  wire logic        i_has_data,
    input  wire logic [7:0]  i_byte_count,
    input  wire logic [7:0]  i_write_data,
    input  wire logic        i_sda_in,
    // result channel
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic             o_scl_release,
    output logic             o_sda_release,
    output logic             o_busy_res,
    output logic             o_byte_taken,
    output logic [7:0]       o_read_data,
    output logic             o_read_valid,
    output logic             o_done_res,
    output logic             o_nack_error,
    // configuration write channel
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [i2cm_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [i2cm_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    logic              r_in_vld;
    i2cm_pkg::t_item   r_in;
    logic              r_out_vld;
    i2cm_pkg::t_result r_out;
    i2cm_pkg::t_cfg    r_cfg;
    i2cm_pkg::t_result w_res;
    logic              w_adv;
    logic              w_accept;

    // Advance a held request when the result register is empty or being drained
    assign w_adv    = r_in_vld && (!r_out_vld || !i_stall);
    assign o_stall  = r_in_vld && !w_adv;
    assign w_accept = i_valid && !o_stall;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (w_accept) begin
                r_in_vld <= 1'b1;
            end else if (w_adv) begin
                r_in_vld <= 1'b0;
            end
            if (w_adv) begin
                r_out_vld <= 1'b1;
            end else if (!i_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in.start_request    <= i_start_request;
            r_in.mode             <= i_mode;
            r_in.device_address   <= i_device_address;
            r_in.register_address <= i_register_address;
            r_in.has_data         <= i_has_data;
            r_in.byte_count       <= i_byte_count;
            r_in.write_data       <= i_write_data;
            r_in.sda_in           <= i_sda_in;
        end
        if (w_adv) begin
            r_out <= w_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.half_period <= i2cm_pkg::HALF_PERIOD_RST;
            r_cfg.ack_timeout <= i2cm_pkg::ACK_TIMEOUT_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                i2cm_pkg::CFG_HALF_PERIOD: r_cfg.half_period <= i_cfg_data[7:0];
                i2cm_pkg::CFG_ACK_TIMEOUT: r_cfg.ack_timeout <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    i2cm_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_item  (r_in),
        .i_cfg   (r_cfg),
        .o_res   (w_res)
    );

    assign o_valid       = r_out_vld;
    assign o_scl_release = r_out.scl_release;
    assign o_sda_release = r_out.sda_release;
    assign o_busy_res    = r_out.busy_res;
    assign o_byte_taken  = r_out.byte_taken;
    assign o_read_data   = r_out.read_data;
    assign o_read_valid  = r_out.read_valid;
    assign o_done_res    = r_out.done_res;
    assign o_nack_error  = r_out.nack_error;

endmodule

`default_nettype wire
